@@ design/dht11_single_wire_reader_macros.svh @@
// Assertion macros for the single-wire sensor reader.
// Included by the top level; no other dependencies.
`ifndef DHT11_SINGLE_WIRE_READER_MACROS_SVH
`define DHT11_SINGLE_WIRE_READER_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked while out of reset.
`define DHTR_ASSERT_IMPLY(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |-> (rhs)) \
        else $error("implication check failed");
// Next-cycle implication, checked while out of reset.
`define DHTR_ASSERT_NEXT(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |=> (rhs)) \
        else $error("next-cycle check failed");
`else
`define DHTR_ASSERT_IMPLY(label, clk, rstn, lhs, rhs)
`define DHTR_ASSERT_NEXT(label, clk, rstn, lhs, rhs)
`endif

`endif

@@ design/dhtr_pkg.sv @@
// Shared types and constants for the single-wire sensor reader.
// No dependencies; used by every module of the block.
package dhtr_pkg;

    // Number of data bits in one sensor frame.
    localparam int FRAME_BITS = 40;
    localparam int BIT_IDX_W  = $clog2(FRAME_BITS + 1);

    // Register reset values.
    localparam logic [15:0] START_LOW_RESET    = 16'd20000;
    localparam logic [7:0]  TIMEOUT_RESET      = 8'd100;
    localparam logic [7:0]  SAMPLE_DELAY_RESET = 8'd30;

    // Configuration register indexes.
    localparam logic [1:0] CFG_START_LOW    = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT      = 2'd1;
    localparam logic [1:0] CFG_SAMPLE_DELAY = 2'd2;

    // Read outcome codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_RESP_LOW  = 3'd1;
    localparam logic [2:0] ST_RESP_HIGH = 3'd2;
    localparam logic [2:0] ST_RESP_GAP  = 3'd3;
    localparam logic [2:0] ST_BIT_HIGH  = 3'd4;
    localparam logic [2:0] ST_BIT_LOW   = 3'd5;

    // Read sequencer phases, one-hot.
    typedef enum logic [7:0] {
        PH_IDLE   = 8'b0000_0001,
        PH_START  = 8'b0000_0010,
        PH_RESP1  = 8'b0000_0100,
        PH_RESP2  = 8'b0000_1000,
        PH_RESP3  = 8'b0001_0000,
        PH_BITHI  = 8'b0010_0000,
        PH_BITLO  = 8'b0100_0000,
        PH_SAMPLE = 8'b1000_0000
    } phase_t;

    // Configuration register set.
    typedef struct packed {
        logic [15:0] start_low_ticks;
        logic [7:0]  timeout_ticks;
        logic [7:0]  sample_delay_ticks;
    } cfg_t;

    // One result item; drive_low sits in the lowest bit when packed.
    typedef struct packed {
        logic [7:0] temperature_frac;
        logic [7:0] temperature_int;
        logic [7:0] humidity_frac;
        logic [7:0] humidity_int;
        logic       checksum_ok;
        logic [2:0] status;
        logic       done_res;
        logic       busy_res;
        logic       drive_low;
    } result_t;

endpackage

@@ design/dhtr_fsm.sv @@
// Read sequencer: phase, tick counter, bit counter, frame shifter and readings.
// Depends on dhtr_pkg.
module dhtr_fsm
    import dhtr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step,          // one tick transfer is accepted
    input  logic    start_request,
    input  logic    line_level,
    input  cfg_t    cfg,
    output result_t res_next
);

    phase_t                  phase_reg,   phase_next;
    logic [15:0]             tick_reg,    tick_next;
    logic [BIT_IDX_W-1:0]    bit_reg,     bit_next;
    logic [FRAME_BITS-1:0]   frame_reg,   frame_next;
    logic [31:0]             reading_reg, reading_next;
    logic [2:0]              status_reg,  status_next;
    logic                    check_reg,   check_next;

    logic [15:0]             tick_inc;
    logic [BIT_IDX_W-1:0]    bit_inc;
    logic [FRAME_BITS-1:0]   frame_shifted;
    logic [7:0]              byte_sum;
    logic                    finished;
    logic                    is_wait;
    logic                    want_level;
    logic [2:0]              wait_code;
    phase_t                  wait_exit;

    assign tick_inc      = tick_reg + 16'd1;
    assign bit_inc       = bit_reg + BIT_IDX_W'(1);
    assign frame_shifted = {frame_reg[FRAME_BITS-2:0], line_level};
    assign byte_sum      = frame_shifted[39:32] + frame_shifted[31:24]
                         + frame_shifted[23:16] + frame_shifted[15:8];

    // Next state for one tick.
    always_comb begin
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        bit_next     = bit_reg;
        frame_next   = frame_reg;
        reading_next = reading_reg;
        status_next  = status_reg;
        check_next   = check_reg;
        finished     = 1'b0;
        is_wait      = 1'b0;
        want_level   = 1'b0;
        wait_code    = ST_OK;
        wait_exit    = PH_IDLE;

        case (phase_reg)
            PH_START: begin
                tick_next = tick_inc;
                if (tick_inc >= cfg.start_low_ticks) begin
                    phase_next = PH_RESP1;
                    tick_next  = 16'd0;
                end
            end
            PH_RESP1: begin
                is_wait    = 1'b1;
                want_level = 1'b0;
                wait_code  = ST_RESP_LOW;
                wait_exit  = PH_RESP2;
            end
            PH_RESP2: begin
                is_wait    = 1'b1;
                want_level = 1'b1;
                wait_code  = ST_RESP_HIGH;
                wait_exit  = PH_RESP3;
            end
            PH_RESP3: begin
                is_wait    = 1'b1;
                want_level = 1'b0;
                wait_code  = ST_RESP_GAP;
                wait_exit  = PH_BITHI;
            end
            PH_BITHI: begin
                is_wait    = 1'b1;
                want_level = 1'b1;
                wait_code  = ST_BIT_HIGH;
                wait_exit  = PH_BITLO;
            end
            PH_BITLO: begin
                is_wait    = 1'b1;
                want_level = 1'b0;
                wait_code  = ST_BIT_LOW;
                wait_exit  = PH_SAMPLE;
            end
            PH_SAMPLE: begin
                tick_next = tick_inc;
                if (tick_inc >= {8'd0, cfg.sample_delay_ticks}) begin
                    frame_next = frame_shifted;
                    bit_next   = bit_inc;
                    tick_next  = 16'd0;
                    if (bit_inc >= BIT_IDX_W'(FRAME_BITS)) begin
                        // Frame complete: update readings only if the checksum matches.
                        if (byte_sum == frame_shifted[7:0]) begin
                            reading_next = frame_shifted[39:8];
                            check_next   = 1'b1;
                        end else begin
                            check_next   = 1'b0;
                        end
                        phase_next  = PH_IDLE;
                        status_next = ST_OK;
                        finished    = 1'b1;
                    end else begin
                        phase_next = PH_BITHI;
                    end
                end
            end
            default: begin
                phase_next = PH_IDLE;
                if (start_request) begin
                    phase_next = PH_START;
                    tick_next  = 16'd0;
                    bit_next   = '0;
                    frame_next = '0;
                end
            end
        endcase

        // Level waits: count matching ticks, leave on the first differing one, end the read past the timeout.
        if (is_wait) begin
            if (line_level == want_level) begin
                tick_next = tick_inc;
                if (tick_inc > {8'd0, cfg.timeout_ticks}) begin
                    phase_next  = PH_IDLE;
                    tick_next   = 16'd0;
                    status_next = wait_code;
                    check_next  = 1'b0;
                    finished    = 1'b1;
                end
            end else begin
                phase_next = wait_exit;
                tick_next  = 16'd0;
            end
        end
    end

    // State registers advance once per accepted tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            tick_reg    <= 16'd0;
            bit_reg     <= '0;
            frame_reg   <= '0;
            reading_reg <= 32'd0;
            status_reg  <= ST_OK;
            check_reg   <= 1'b0;
        end else if (step) begin
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            bit_reg     <= bit_next;
            frame_reg   <= frame_next;
            reading_reg <= reading_next;
            status_reg  <= status_next;
            check_reg   <= check_next;
        end
    end

    // Result shows the state after this tick.
    always_comb begin
        res_next.drive_low        = (phase_next == PH_START);
        res_next.busy_res         = (phase_next != PH_IDLE);
        res_next.done_res         = finished;
        res_next.status           = status_next;
        res_next.checksum_ok      = check_next;
        res_next.humidity_int     = reading_next[31:24];
        res_next.humidity_frac    = reading_next[23:16];
        res_next.temperature_int  = reading_next[15:8];
        res_next.temperature_frac = reading_next[7:0];
    end

endmodule

@@ design/dhtr_out_stage.sv @@
// Result register with stream handshake for the sensor reader.
// Depends on dhtr_pkg.
module dhtr_out_stage
    import dhtr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    valid_reg, valid_next;
    result_t data_reg;
    logic    load;

    // A new result may enter whenever the held one is empty or leaving.
    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload register needs no reset.
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= in_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ design/dht11_single_wire_reader.sv @@
// Single-wire humidity and temperature sensor reader, top level.
// Depends on dhtr_pkg, dhtr_fsm, dhtr_out_stage and the assertion macro header.
//
// Usage: feed one transfer per microsecond tick on the s_ channel carrying
// the sampled wire level and a start request. Each accepted tick yields
// exactly one result transfer on the m_ channel: the open-drain drive, busy
// and done flags, the status of the last read, the checksum flag and the
// four bytes of the last good reading, all as they stand after that tick.
// A result turns valid in the cycle after its input transfer. Throughput is
// one tick per cycle while m_tready keeps up: the sequencer's next-state
// logic and the result register both take a new tick every such cycle.
// A held result does not block the input while the receiver takes it in
// the same cycle; when m_tready stays low, s_tready falls and the tick
// waits. The sequencer only advances on accepted ticks.
// Reset (aresetn low, synchronous) returns the sequencer to idle, clears
// the readings and status, empties the result register and reloads the
// register defaults. Configuration writes are taken in any cycle; index
// values beyond the register list are ignored.
`include "dht11_single_wire_reader_macros.svh"

module dht11_single_wire_reader
    import dhtr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    // Tick input.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] start_request, [1] line_level, [7:2] zero
    // Result output.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [0] drive_low, [1] busy_res, [2] done_res,
                                   // [5:3] status, [6] checksum_ok,
                                   // [14:7] humidity_int, [22:15] humidity_frac,
                                   // [30:23] temperature_int,
                                   // [38:31] temperature_frac, [39] zero
);

    cfg_t    cfg_reg;
    result_t res_next;
    result_t res_out;
    logic    step;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_low_ticks    <= START_LOW_RESET;
            cfg_reg.timeout_ticks      <= TIMEOUT_RESET;
            cfg_reg.sample_delay_ticks <= SAMPLE_DELAY_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_START_LOW:    cfg_reg.start_low_ticks    <= cfg_wdata;
                CFG_TIMEOUT:      cfg_reg.timeout_ticks      <= cfg_wdata[7:0];
                CFG_SAMPLE_DELAY: cfg_reg.sample_delay_ticks <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign step = s_tvalid && s_tready;

    dhtr_fsm u_fsm (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .start_request (s_tdata[0]),
        .line_level    (s_tdata[1]),
        .cfg           (cfg_reg),
        .res_next      (res_next)
    );

    dhtr_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (res_next),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res_out)
    );

    assign m_tdata = {1'b0, res_out};

    // Every accepted tick leaves a result waiting in the next cycle.
    `DHTR_ASSERT_NEXT(a_tick_gives_result, aclk, aresetn, step, m_tvalid)
    // A stalled result holds the input back.
    `DHTR_ASSERT_IMPLY(a_stall_blocks_input, aclk, aresetn, m_tvalid && !m_tready, !s_tready)
    // A read that ends leaves the sequencer idle and the wire released.
    `DHTR_ASSERT_IMPLY(a_done_is_idle, aclk, aresetn, step && res_next.done_res, !res_next.busy_res && !res_next.drive_low)

endmodule
